// ===== src/hht_pkg.sv =====
package hht_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // most results one input byte can produce
    localparam int MAX_RES = 3;

    typedef enum logic [2:0]
    {
        ROLE_METHOD  = 3'd0,
        ROLE_URI     = 3'd1,
        ROLE_VERSION = 3'd2,
        ROLE_NAME    = 3'd3,
        ROLE_VALUE   = 3'd4,
        ROLE_DISCARD = 3'd5
    } role_t;

    typedef enum logic [1:0]
    {
        ST_RUNNING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_SHORT    = 2'd2,
        ST_MANY     = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [15:0] pos;
        logic [7:0]  data;
        role_t       role;
        logic [3:0]  hnum;
        status_t     status;
        logic [4:0]  total;
        logic        last;
    } res_t;

endpackage

// ===== src/http_header_tokenizer.sv =====
// Each result is written into the queue's registers and reaches m_axis at the queue head.
// Throughput: one input word and one result word per cycle, each while its tready holds.
// A word gives zero to three results (CR/LF are held and released later); results
// go through a 4-entry queue and s_axis_tready drops while fewer than 3 entries are free.
// rst_n (async, active low) clears parse state and empties the queue.
module http_header_tokenizer #(
    parameter int MAX_HEADERS       = 16,
    parameter int MAX_REQUEST_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // first_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // byte_position, tagged_byte, header_number,
                                        // parse_status, header_total, zero pad
    output logic [2:0]  m_axis_tuser,   // role
    output logic        m_axis_tlast    // run_end
);
    import hht_pkg::*;

    logic       accept;
    logic [1:0] res_count;
    res_t [2:0] results;
    res_t       head;

    assign accept = s_axis_tvalid && s_axis_tready;

    hht_core #(
        .MAX_HEADERS       (MAX_HEADERS),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .first_byte (s_axis_tuser),
        .final_byte (s_axis_tlast),
        .res_count  (res_count),
        .results    (results)
    );

    hht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_count (res_count),
        .push_data  (results),
        .space      (s_axis_tready),
        .pop_valid  (m_axis_tvalid),
        .pop_ready  (m_axis_tready),
        .pop_data   (head)
    );

    assign m_axis_tdata = {5'd0, head.total, head.status, head.hnum, head.data, head.pos};
    assign m_axis_tuser = head.role;
    assign m_axis_tlast = head.last;

endmodule

// ===== src/hht_core.sv =====
module hht_core #(
    parameter int MAX_HEADERS       = 16,
    parameter int MAX_REQUEST_BYTES = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                final_byte,
    output logic [1:0]          res_count,
    output hht_pkg::res_t [2:0] results
);
    import hht_pkg::*;

    localparam int LW = $clog2(MAX_HEADERS + 1);

    typedef enum logic [2:0]
    {
        PH_REQ   = 3'd0,
        PH_LINE  = 3'd1,
        PH_NAME  = 3'd2,
        PH_VALUE = 3'd3,
        PH_DONE  = 3'd4,
        PH_SHORT = 3'd5,
        PH_MANY  = 3'd6
    } phase_t;

    phase_t          phase_reg;
    logic [1:0]      token_reg;
    logic            closed_reg;
    logic [LW-1:0]   line_reg;
    logic [31:0]     offset_reg;
    logic            begun_reg;
    logic [1:0]      la_cnt_reg;
    logic [7:0]      la_reg [2];

    phase_t          phase_next;
    logic [1:0]      token_next;
    logic            closed_next;
    logic [LW-1:0]   line_next;
    logic            begun_next;
    logic [1:0]      la_cnt_next;
    logic [7:0]      la0_next;
    logic [7:0]      la1_next;

    logic [31:0]     offset_cur;
    logic [15:0]     p;
    logic [15:0]     start;
    logic [7:0]      b;
    logic [1:0]      n;
    logic            ls_go;
    logic            nm_go;
    logic            val_go;
    res_t [2:0]      res;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_running(phase_t ph);
        return (ph == PH_REQ) || (ph == PH_LINE) || (ph == PH_NAME) || (ph == PH_VALUE);
    endfunction

    function automatic logic over_headers(logic [LW-1:0] li);
        return 32'(li) >= 32'(MAX_HEADERS);
    endfunction

    function automatic res_t mk(logic [15:0] pp, logic [7:0] d, role_t r, phase_t ph,
                                logic [LW-1:0] li);
        res_t        o;
        logic [31:0] lx;
        lx     = 32'(li);
        o.pos  = pp;
        o.data = d;
        o.role = r;
        o.hnum = lx[3:0];
        case (ph)
            PH_DONE:  o.status = ST_COMPLETE;
            PH_SHORT: o.status = ST_SHORT;
            PH_MANY:  o.status = ST_MANY;
            default:  o.status = ST_RUNNING;
        endcase
        o.total = (ph == PH_DONE) ? lx[4:0] : 5'd0;
        o.last  = 1'b0;
        return o;
    endfunction

    always_comb
    begin
        phase_next  = first_byte ? PH_REQ : phase_reg;
        token_next  = first_byte ? 2'd0 : token_reg;
        closed_next = first_byte ? 1'b0 : closed_reg;
        line_next   = first_byte ? '0 : line_reg;
        begun_next  = first_byte ? 1'b0 : begun_reg;
        la_cnt_next = first_byte ? 2'd0 : la_cnt_reg;
        offset_cur  = first_byte ? 32'd0 : offset_reg;
        la0_next    = la_reg[0];
        la1_next    = la_reg[1];
        p           = offset_cur[15:0];
        b           = data_byte;
        start       = 16'd0;
        n           = 2'd0;
        ls_go       = 1'b0;
        nm_go       = 1'b0;
        val_go      = 1'b0;
        res         = '0;

        if (is_running(phase_next) && offset_cur >= 32'(MAX_REQUEST_BYTES))
        begin
            phase_next = PH_SHORT;
            start      = p - {14'd0, la_cnt_next};
            if (la_cnt_next != 2'd0)
            begin
                res[n] = mk(start, la0_next, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            if (la_cnt_next == 2'd2)
            begin
                res[n] = mk(start + 16'd1, la1_next, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            la_cnt_next = 2'd0;
            res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
            n = n + 2'd1;
        end
        else
        begin
            unique case (phase_next)
                PH_REQ:
                begin
                    if (b == CH_SPACE && token_next < 2'd2)
                    begin
                        res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                        n = n + 2'd1;
                        token_next = token_next + 2'd1;
                    end
                    else if (b == CH_CR)
                    begin
                        res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                        n = n + 2'd1;
                    end
                    else if (b == CH_LF)
                    begin
                        if (token_next < 2'd2)
                        begin
                            phase_next = PH_SHORT;
                        end
                        else
                        begin
                            phase_next = PH_LINE;
                            line_next  = '0;
                        end
                        res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = mk(p, b, role_t'({1'b0, token_next}), phase_next, line_next);
                        n = n + 2'd1;
                    end
                end
                PH_LINE:
                begin
                    if (la_cnt_next == 2'd0)
                    begin
                        ls_go = 1'b1;
                    end
                    else
                    begin
                        la_cnt_next = 2'd0;
                        if (b == CH_LF)
                        begin
                            res[n] = mk(p - 16'd1, CH_CR, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                            phase_next = PH_DONE;
                            res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            phase_next = over_headers(line_next) ? PH_MANY : PH_SHORT;
                            res[n] = mk(p - 16'd1, CH_CR, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                            res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                        end
                    end
                end
                PH_NAME:
                begin
                    nm_go = 1'b1;
                end
                PH_VALUE:
                begin
                    if (la_cnt_next == 2'd0)
                    begin
                        val_go = 1'b1;
                    end
                    else if (la_cnt_next == 2'd1 && la0_next == CH_LF)
                    begin
                        la_cnt_next = 2'd0;
                        if (is_blank(b))
                        begin
                            res[n] = mk(p - 16'd1, CH_SPACE, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                            res[n] = mk(p, CH_SPACE, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            res[n] = mk(p - 16'd1, CH_LF, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                            line_next  = line_next + LW'(1);
                            phase_next = PH_LINE;
                            ls_go      = 1'b1;
                        end
                    end
                    else if (la_cnt_next == 2'd1)
                    begin
                        if (b == CH_LF)
                        begin
                            la1_next    = b;
                            la_cnt_next = 2'd2;
                        end
                        else
                        begin
                            la_cnt_next = 2'd0;
                            res[n] = mk(p - 16'd1, CH_CR, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                            val_go = 1'b1;
                        end
                    end
                    else
                    begin
                        la_cnt_next = 2'd0;
                        if (is_blank(b))
                        begin
                            res[n] = mk(p - 16'd2, CH_SPACE, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                            res[n] = mk(p - 16'd1, CH_SPACE, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                            res[n] = mk(p, CH_SPACE, ROLE_VALUE, phase_next, line_next);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            res[n] = mk(p - 16'd2, CH_CR, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                            res[n] = mk(p - 16'd1, CH_LF, ROLE_DISCARD, phase_next, line_next);
                            n = n + 2'd1;
                            line_next  = line_next + LW'(1);
                            phase_next = PH_LINE;
                            ls_go      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                    n = n + 2'd1;
                end
            endcase
        end

        // start of a header line
        if (ls_go)
        begin
            if (b == CH_LF)
            begin
                phase_next = PH_DONE;
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            else if (b == CH_CR)
            begin
                if (la_cnt_next == 2'd0)
                begin
                    la0_next    = b;
                    la_cnt_next = 2'd1;
                end
                else if (la_cnt_next == 2'd1)
                begin
                    la1_next    = b;
                    la_cnt_next = 2'd2;
                end
            end
            else if (over_headers(line_next))
            begin
                phase_next = PH_MANY;
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            else
            begin
                phase_next  = PH_NAME;
                closed_next = 1'b0;
                nm_go       = 1'b1;
            end
        end

        // header name byte
        if (nm_go)
        begin
            if (b == CH_COLON)
            begin
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
                phase_next = PH_VALUE;
                begun_next = 1'b0;
            end
            else if (is_blank(b))
            begin
                closed_next = 1'b1;
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            else if (b == CH_LF || b == CH_CR)
            begin
                phase_next = PH_SHORT;
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            else
            begin
                res[n] = mk(p, b, closed_next ? ROLE_DISCARD : ROLE_NAME, phase_next, line_next);
                n = n + 2'd1;
            end
        end

        // header value byte
        if (val_go)
        begin
            if (!begun_next && !is_blank(b))
            begin
                begun_next = 1'b1;
            end
            if (b == CH_LF || b == CH_CR)
            begin
                if (la_cnt_next == 2'd0)
                begin
                    la0_next    = b;
                    la_cnt_next = 2'd1;
                end
                else if (la_cnt_next == 2'd1)
                begin
                    la1_next    = b;
                    la_cnt_next = 2'd2;
                end
            end
            else
            begin
                res[n] = mk(p, b, begun_next ? ROLE_VALUE : ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
        end

        // buffer ends while still parsing
        if (is_running(phase_next) && final_byte)
        begin
            start      = p + 16'd1 - {14'd0, la_cnt_next};
            phase_next = PH_SHORT;
            if (la_cnt_next != 2'd0)
            begin
                res[n] = mk(start, la0_next, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            if (la_cnt_next == 2'd2)
            begin
                res[n] = mk(start + 16'd1, la1_next, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
            la_cnt_next = 2'd0;
            if (n != 2'd0)
            begin
                res[n - 2'd1].status = ST_SHORT;
                res[n - 2'd1].total  = 5'd0;
            end
            else
            begin
                res[n] = mk(p, b, ROLE_DISCARD, phase_next, line_next);
                n = n + 2'd1;
            end
        end

        if (n != 2'd0)
        begin
            res[n - 2'd1].last = 1'b1;
        end
    end

    assign res_count = n;
    assign results   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_REQ;
            token_reg  <= 2'd0;
            closed_reg <= 1'b0;
            line_reg   <= '0;
            offset_reg <= 32'd0;
            begun_reg  <= 1'b0;
            la_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            token_reg  <= token_next;
            closed_reg <= closed_next;
            line_reg   <= line_next;
            offset_reg <= offset_cur + 32'd1;
            begun_reg  <= begun_next;
            la_cnt_reg <= la_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            la_reg[0] <= la0_next;
            la_reg[1] <= la1_next;
        end
    end

endmodule

// ===== src/hht_queue.sv =====
module hht_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [1:0]          push_count,
    input  hht_pkg::res_t [2:0] push_data,
    output logic                space,
    output logic                pop_valid,
    input  logic                pop_ready,
    output hht_pkg::res_t       pop_data
);
    import hht_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    res_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic [AW-1:0] slot_off [DEPTH];
    logic          pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign space     = (32'(count_reg) <= DEPTH - MAX_RES);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_off[i] = AW'(i) - wr_ptr_reg;
        end
        wr_ptr_next = push ? wr_ptr_reg + AW'(push_count) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (push ? CW'(push_count) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push && 32'(slot_off[i]) < 32'(push_count))
            begin
                case (slot_off[i])
                    AW'(0):  entry_reg[i] <= push_data[0];
                    AW'(1):  entry_reg[i] <= push_data[1];
                    AW'(2):  entry_reg[i] <= push_data[2];
                    default: entry_reg[i] <= entry_reg[i];
                endcase
            end
        end
    end

endmodule

// ===== tb/hht_checker.sv =====
`timescale 1ns / 1ps

module hht_checker #(
    parameter int MAX_HEADERS       = 16,
    parameter int MAX_REQUEST_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import hht_pkg::*;

    typedef enum logic [2:0]
    {
        PH_REQUEST,
        PH_LINE_START,
        PH_NAME,
        PH_VALUE,
        PH_DONE,
        PH_SHORT,
        PH_MANY
    } phase_e;

    phase_e      phase;
    logic [1:0]  req_field;
    logic        name_cut;
    int unsigned line_no;
    int unsigned offset;
    logic        in_value;
    logic [7:0]  held [2];
    int          held_n;
    res_t        step_q [$];
    res_t        tag_q [$];

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic status_t cur_status();
        case (phase)
            PH_DONE:  return ST_COMPLETE;
            PH_SHORT: return ST_SHORT;
            PH_MANY:  return ST_MANY;
            default:  return ST_RUNNING;
        endcase
    endfunction

    function automatic void clear_state();
        phase     = PH_REQUEST;
        req_field = 2'd0;
        name_cut  = 1'b0;
        line_no   = 0;
        offset    = 0;
        in_value  = 1'b0;
        held[0]   = 8'h00;
        held[1]   = 8'h00;
        held_n    = 0;
    endfunction

    function automatic void tag(int unsigned pos, logic [7:0] b, role_t r);
        res_t t;
        if (step_q.size() >= MAX_RES)
            return;
        t.pos    = pos[15:0];
        t.data   = b;
        t.role   = r;
        t.hnum   = line_no[3:0];
        t.status = cur_status();
        t.total  = (t.status == ST_COMPLETE) ? line_no[4:0] : 5'd0;
        t.last   = 1'b0;
        step_q.push_back(t);
    endfunction

    function automatic void release_held(int unsigned first_pos);
        for (int i = 0; i < held_n; i++)
            tag(first_pos + i, held[i], ROLE_DISCARD);
        held_n = 0;
    endfunction

    function automatic void hold_byte(logic [7:0] b);
        if (held_n < 2)
        begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void on_name_byte(logic [7:0] b, int unsigned pos);
        if (b == CH_COLON)
        begin
            tag(pos, b, ROLE_DISCARD);
            phase    = PH_VALUE;
            in_value = 1'b0;
        end
        else if (is_blank(b))
        begin
            name_cut = 1'b1;
            tag(pos, b, ROLE_DISCARD);
        end
        else if (b == CH_LF || b == CH_CR)
        begin
            phase = PH_SHORT;
            tag(pos, b, ROLE_DISCARD);
        end
        else
            tag(pos, b, name_cut ? ROLE_DISCARD : ROLE_NAME);
    endfunction

    function automatic void on_line_start(logic [7:0] b, int unsigned pos);
        if (b == CH_LF)
        begin
            phase = PH_DONE;
            tag(pos, b, ROLE_DISCARD);
        end
        else if (b == CH_CR)
            hold_byte(b);
        else if (line_no >= MAX_HEADERS)
        begin
            phase = PH_MANY;
            tag(pos, b, ROLE_DISCARD);
        end
        else
        begin
            phase    = PH_NAME;
            name_cut = 1'b0;
            on_name_byte(b, pos);
        end
    endfunction

    function automatic void on_value_byte(logic [7:0] b, int unsigned pos);
        if (!in_value && !is_blank(b))
            in_value = 1'b1;
        if (b == CH_LF || b == CH_CR)
            hold_byte(b);
        else
            tag(pos, b, in_value ? ROLE_VALUE : ROLE_DISCARD);
    endfunction

    function automatic void close_line();
        line_no++;
        phase = PH_LINE_START;
    endfunction

    function automatic void on_request_byte(logic [7:0] b, int unsigned pos);
        if (b == CH_SPACE && req_field < 2)
        begin
            tag(pos, b, ROLE_DISCARD);
            req_field++;
        end
        else if (b == CH_CR)
            tag(pos, b, ROLE_DISCARD);
        else if (b == CH_LF)
        begin
            if (req_field < 2)
                phase = PH_SHORT;
            else
            begin
                phase   = PH_LINE_START;
                line_no = 0;
            end
            tag(pos, b, ROLE_DISCARD);
        end
        else
            tag(pos, b, role_t'({1'b0, req_field}));
    endfunction

    function automatic void dispatch(logic [7:0] b, int unsigned pos);
        int n;
        n = held_n;
        case (phase)
            PH_REQUEST:
                on_request_byte(b, pos);
            PH_LINE_START:
                if (n == 0)
                    on_line_start(b, pos);
                else
                begin
                    held_n = 0;
                    if (b == CH_LF)
                    begin
                        tag(pos - 1, CH_CR, ROLE_DISCARD);
                        phase = PH_DONE;
                        tag(pos, b, ROLE_DISCARD);
                    end
                    else
                    begin
                        phase = (line_no >= MAX_HEADERS) ? PH_MANY : PH_SHORT;
                        tag(pos - 1, CH_CR, ROLE_DISCARD);
                        tag(pos, b, ROLE_DISCARD);
                    end
                end
            PH_NAME:
                on_name_byte(b, pos);
            PH_VALUE:
                if (n == 0)
                    on_value_byte(b, pos);
                else if (n == 1 && held[0] == CH_LF)
                begin
                    held_n = 0;
                    if (is_blank(b))
                    begin
                        tag(pos - 1, CH_SPACE, ROLE_VALUE);
                        tag(pos, CH_SPACE, ROLE_VALUE);
                    end
                    else
                    begin
                        tag(pos - 1, CH_LF, ROLE_DISCARD);
                        close_line();
                        on_line_start(b, pos);
                    end
                end
                else if (n == 1)
                begin
                    if (b == CH_LF)
                        hold_byte(b);
                    else
                    begin
                        held_n = 0;
                        tag(pos - 1, CH_CR, ROLE_VALUE);
                        on_value_byte(b, pos);
                    end
                end
                else
                begin
                    held_n = 0;
                    if (is_blank(b))
                    begin
                        tag(pos - 2, CH_SPACE, ROLE_VALUE);
                        tag(pos - 1, CH_SPACE, ROLE_VALUE);
                        tag(pos, CH_SPACE, ROLE_VALUE);
                    end
                    else
                    begin
                        tag(pos - 2, CH_CR, ROLE_DISCARD);
                        tag(pos - 1, CH_LF, ROLE_DISCARD);
                        close_line();
                        on_line_start(b, pos);
                    end
                end
            default:
                tag(pos, b, ROLE_DISCARD);
        endcase
    endfunction

    function automatic void tokenize(logic [7:0] b, logic first, logic fin);
        int unsigned pos;
        res_t        t;
        step_q.delete();
        if (first)
            clear_state();
        pos = offset;
        offset++;

        if (phase < PH_DONE && pos >= MAX_REQUEST_BYTES)
        begin
            phase = PH_SHORT;
            release_held(pos - held_n);
            tag(pos, b, ROLE_DISCARD);
        end
        else
            dispatch(b, pos);

        // buffer ran out mid-parse: held bytes go out, last word says unexpected end
        if (phase < PH_DONE && fin)
        begin
            phase = PH_SHORT;
            release_held(pos + 1 - held_n);
            if (step_q.size() > 0)
            begin
                t = step_q.pop_back();
                t.status = ST_SHORT;
                t.total  = 5'd0;
                step_q.push_back(t);
            end
            else
                tag(pos, b, ROLE_DISCARD);
        end

        if (step_q.size() > 0)
        begin
            t = step_q.pop_back();
            t.last = 1'b1;
            step_q.push_back(t);
        end
        foreach (step_q[i])
            tag_q.push_back(step_q[i]);
    endfunction

    function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_word();
        res_t want;
        if (tag_q.size() == 0)
        begin
            $error("unexpected word at byte_position %0d", m_axis_tdata[15:0]);
            fail_count++;
            return;
        end
        want = tag_q.pop_front();
        check_field("byte_position", want.pos, m_axis_tdata[15:0]);
        check_field("tagged_byte", want.data, m_axis_tdata[23:16]);
        check_field("role", want.role, m_axis_tuser);
        check_field("header_number", want.hnum, m_axis_tdata[27:24]);
        check_field("parse_status", want.status, m_axis_tdata[29:28]);
        check_field("header_total", want.total, m_axis_tdata[34:30]);
        check_field("run_end", want.last, m_axis_tlast);
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_state();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            tag_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready)
                tokenize(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            pending = tag_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hht_pkg::*;

    localparam int MAX_HEADERS       = 16;
    localparam int MAX_REQUEST_BYTES = 65536;
    localparam int CYCLE_LIMIT       = 60000;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_first;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;
    logic [2:0]  m_role;
    logic        m_last;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    logic        calm = 1'b0;
    int          words_sent = 0;
    logic [7:0]  req_q [$];

    http_header_tokenizer #(
        .MAX_HEADERS       (MAX_HEADERS),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_first),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_role),
        .m_axis_tlast  (m_last)
    );

    hht_checker #(
        .MAX_HEADERS       (MAX_HEADERS),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_first),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_role),
        .m_axis_tlast  (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte(bit sp_ok, bit tab_ok, bit colon_ok);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || (!sp_ok && c == CH_SPACE)
               || (!tab_ok && c == CH_TAB) || (!colon_ok && c == CH_COLON));
        return c;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            req_q.push_back(s[i]);
    endfunction

    function automatic void push_blank();
        req_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void push_eol();
        if ($urandom_range(0, 1))
            req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
    endfunction

    function automatic void push_request_line(bit one_space);
        repeat ($urandom_range(1, 3)) req_q.push_back(pick_byte(0, 1, 1));
        req_q.push_back(CH_SPACE);
        repeat ($urandom_range(1, 3)) req_q.push_back(pick_byte(0, 1, 1));
        if (!one_space)
        begin
            req_q.push_back(CH_SPACE);
            repeat ($urandom_range(1, 3)) req_q.push_back(pick_byte(1, 1, 1));
        end
        push_eol();
    endfunction

    function automatic void push_header(int name_max, int val_max, bit folds);
        repeat ($urandom_range(1, name_max)) req_q.push_back(pick_byte(0, 0, 0));
        if ($urandom_range(0, 4) == 0)
        begin
            push_blank();
            req_q.push_back(pick_byte(0, 0, 0));
        end
        req_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) push_blank();
        repeat ($urandom_range(0, val_max)) req_q.push_back(pick_byte(1, 1, 1));
        if (folds)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        req_q.push_back(CH_LF);
                        push_blank();
                    end
                    1:
                    begin
                        req_q.push_back(CH_CR);
                        req_q.push_back(CH_LF);
                        push_blank();
                    end
                    default:
                        req_q.push_back(CH_CR);
                endcase
                req_q.push_back(pick_byte(1, 1, 1));
            end
        end
        push_eol();
    endfunction

    task automatic send_word(input logic [7:0] b, input logic f, input logic l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid = 1'b1;
        s_data  = b;
        s_first = f;
        s_last  = l;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        s_valid = 1'b0;
        words_sent++;
    endtask

    task automatic send_request(input logic with_first, input logic with_last);
        for (int i = 0; i < req_q.size(); i++)
            send_word(req_q[i], with_first && i == 0, with_last && i == req_q.size() - 1);
        req_q.delete();
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin : sink
        int gap;
        m_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_ready = 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int   req_no;
        int   base;
        int   kind;
        int   nh;
        int   cut;
        logic with_last;

        rst_n   = 1'b0;
        s_valid = 1'b0;
        s_data  = 8'h00;
        s_first = 1'b0;
        s_last  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extreme bytes, complete with no headers, then a word after the end
        req_q = '{8'hFF, CH_SPACE, 8'h00, CH_SPACE, CH_LF, CH_LF};
        send_request(1'b1, 1'b0);
        send_word("x", 1'b0, 1'b1);
        // request line with only one token
        push_text("a");
        req_q.push_back(CH_LF);
        push_text("b");
        send_request(1'b1, 1'b1);
        send_word("a", 1'b1, 1'b1);
        // CR in request line, blank in name, leading blanks, end with two held bytes
        push_text("A B C");
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
        push_text("N x:");
        req_q.push_back(CH_TAB);
        push_text(" v");
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
        send_request(1'b1, 1'b1);
        drain();

        req_no = 0;
        base   = words_sent;
        while (req_no < 9 || words_sent - base < 170)
        begin
            if (req_no < 9)
                kind = req_no;
            else
                kind = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            calm      = ($urandom_range(0, 3) == 0);
            with_last = $urandom_range(0, 1);
            case (kind)
                0:
                begin
                    push_request_line(0);
                    repeat ($urandom_range(0, 3)) push_header(3, 3, $urandom_range(0, 1));
                    push_eol();
                end
                1:
                begin
                    push_request_line(0);
                    repeat ($urandom_range(1, 3)) push_header(3, 3, 1);
                    push_eol();
                end
                2:
                begin
                    push_request_line(0);
                    nh = $urandom_range(15, 17);
                    repeat (nh) push_header(1, 0, 0);
                    push_eol();
                end
                3:
                begin
                    push_request_line(0);
                    nh = $urandom_range(0, 1) ? MAX_HEADERS : $urandom_range(0, 2);
                    repeat (nh) push_header(1, 1, 0);
                    req_q.push_back(CH_CR);
                    req_q.push_back(pick_byte(1, 1, 1));
                    push_eol();
                end
                4:
                begin
                    push_request_line(0);
                    repeat ($urandom_range(0, 1)) push_header(2, 2, 0);
                    repeat ($urandom_range(1, 2)) req_q.push_back(pick_byte(0, 0, 0));
                    req_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                    push_eol();
                end
                5:
                begin
                    push_request_line(1);
                    push_header(2, 2, 0);
                    push_eol();
                end
                6:
                begin
                    push_request_line(0);
                    repeat ($urandom_range(1, 2)) push_header(3, 3, 1);
                    push_eol();
                    cut = $urandom_range(1, req_q.size());
                    while (req_q.size() > cut)
                        req_q.delete(req_q.size() - 1);
                    with_last = 1'b1;
                end
                7:
                begin
                    push_request_line(0);
                    repeat ($urandom_range(0, 2)) push_header(2, 2, 0);
                    push_eol();
                    repeat ($urandom_range(1, 4)) req_q.push_back(8'($urandom_range(0, 255)));
                end
                default:
                    repeat ($urandom_range(1, 6))
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0);
            endcase
            send_request(1'b1, with_last);
            if (req_no % 4 == 3)
                drain();
            req_no++;
        end

        s_valid = 1'b0;
        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
